// File: design/jtsc_pkg.sv
package jtsc_pkg;

    // Field widths
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 2;
    localparam int EVENT_W  = 4;
    localparam int ERROR_W  = 3;
    localparam int DEPTH_W  = 7;
    localparam int MASK_W   = 10;
    localparam int CTX_W    = 2;

    // Token kinds from the lexer
    localparam logic [KIND_W-1:0] KIND_END       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_OBJ_OPEN  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_OBJ_CLOSE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ARR_OPEN  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ARR_CLOSE = 4'd4;
    localparam logic [KIND_W-1:0] KIND_COLON     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_STRING    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_BOOL      = 4'd8;
    localparam logic [KIND_W-1:0] KIND_NUMBER    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_NULL      = 4'd10;

    // Result status
    localparam logic [STATUS_W-1:0] STATUS_CONT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR    = 2'd2;

    // Structural events
    localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;
    localparam logic [EVENT_W-1:0] EV_OBJ_OPEN  = 4'd1;
    localparam logic [EVENT_W-1:0] EV_ARR_OPEN  = 4'd2;
    localparam logic [EVENT_W-1:0] EV_KEY       = 4'd3;
    localparam logic [EVENT_W-1:0] EV_MEMBER    = 4'd4;
    localparam logic [EVENT_W-1:0] EV_ELEMENT   = 4'd5;
    localparam logic [EVENT_W-1:0] EV_OBJ_CLOSE = 4'd6;
    localparam logic [EVENT_W-1:0] EV_ARR_CLOSE = 4'd7;
    localparam logic [EVENT_W-1:0] EV_SEP       = 4'd8;
    localparam logic [EVENT_W-1:0] EV_END       = 4'd9;

    // Error kinds
    localparam logic [ERROR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERROR_W-1:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [ERROR_W-1:0] ERR_INVALID    = 3'd2;
    localparam logic [ERROR_W-1:0] ERR_LEXEME     = 3'd3;
    localparam logic [ERROR_W-1:0] ERR_OVERFLOW   = 3'd4;

    // Context codes held in the stack cells
    localparam logic [CTX_W-1:0] CTX_NONE   = 2'd0;
    localparam logic [CTX_W-1:0] CTX_OBJECT = 2'd1;
    localparam logic [CTX_W-1:0] CTX_ARRAY  = 2'd2;
    localparam logic [CTX_W-1:0] CTX_KEY    = 2'd3;

    // Expected-token mask bits
    localparam logic [MASK_W-1:0] EX_OBJ_BEGIN = 10'h001;
    localparam logic [MASK_W-1:0] EX_OBJ_KEY   = 10'h002;
    localparam logic [MASK_W-1:0] EX_OBJ_VALUE = 10'h004;
    localparam logic [MASK_W-1:0] EX_OBJ_END   = 10'h008;
    localparam logic [MASK_W-1:0] EX_ARR_BEGIN = 10'h010;
    localparam logic [MASK_W-1:0] EX_ARR_VALUE = 10'h020;
    localparam logic [MASK_W-1:0] EX_ARR_END   = 10'h040;
    localparam logic [MASK_W-1:0] EX_COLON     = 10'h080;
    localparam logic [MASK_W-1:0] EX_COMMA     = 10'h100;
    localparam logic [MASK_W-1:0] EX_DOC_END   = 10'h200;

    localparam logic [MASK_W-1:0] MASK_RESTART = EX_OBJ_BEGIN | EX_ARR_BEGIN;

    // Configuration register addresses (byte)
    localparam logic [2:0] ADDR_MAX_DEPTH = 3'd0;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 7'd64;

    typedef logic [CTX_W-1:0]  ctx_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic              lexeme_ok;
    } tok_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [EVENT_W-1:0]  event_res;
        logic [ERROR_W-1:0]  error_kind;
        logic [DEPTH_W-1:0]  depth;
    } res_t;

    // Shift command for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop1;
        logic pop2;
        ctx_t push_ctx;
    } stack_op_t;

endpackage

// File: design/jtsc_cell.sv
// One stack entry; shifts towards the bottom on push and towards the top on pop
module jtsc_cell (
    input  logic               clk,
    input  jtsc_pkg::stack_op_t op,
    input  jtsc_pkg::ctx_t     from_prev,
    input  jtsc_pkg::ctx_t     from_next,
    input  jtsc_pkg::ctx_t     from_next2,
    output jtsc_pkg::ctx_t     ctx
);

    jtsc_pkg::ctx_t ctx_reg;
    jtsc_pkg::ctx_t ctx_next;

    always_comb
    begin
        ctx_next = ctx_reg;
        if (op.push)
        begin
            ctx_next = from_prev;
        end
        else if (op.pop1)
        begin
            ctx_next = from_next;
        end
        else if (op.pop2)
        begin
            ctx_next = from_next2;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
    end

    assign ctx = ctx_reg;

endmodule

// File: design/jtsc_ctrl.sv
// Token decode: checks the token against the expected mask and the top of stack
module jtsc_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                        fire,
    input  jtsc_pkg::tok_t              tok,
    input  jtsc_pkg::mask_t             mask,
    input  logic [CW-1:0]               count,
    input  jtsc_pkg::ctx_t              top0,
    input  jtsc_pkg::ctx_t              top1,
    input  logic [jtsc_pkg::DEPTH_W-1:0] max_depth,
    output jtsc_pkg::mask_t             mask_next,
    output logic [CW-1:0]               count_next,
    output jtsc_pkg::stack_op_t         op,
    output jtsc_pkg::res_t              result
);

    localparam int DW = (CW > jtsc_pkg::DEPTH_W) ? CW : jtsc_pkg::DEPTH_W;

    jtsc_pkg::ctx_t                  top_ctx;
    jtsc_pkg::ctx_t                  need_ctx;
    logic                            lim_hit;
    logic                            cnt_one;
    logic                            cnt_ge2;
    logic                            cnt_ge3;
    logic [DW-1:0]                   cnt_ext;
    logic [DW-1:0]                   cnt_out_ext;

    // Close outcome, shared by both close tokens
    logic                            cl_err;
    logic                            cl_pop1;
    logic                            cl_pop2;
    jtsc_pkg::mask_t                 cl_mask;

    logic [jtsc_pkg::ERROR_W-1:0]    err;
    logic [jtsc_pkg::STATUS_W-1:0]   st;
    logic [jtsc_pkg::EVENT_W-1:0]    ev;
    jtsc_pkg::mask_t                 m_n;
    logic [CW-1:0]                   c_n;
    logic                            push;
    logic                            pop1;
    logic                            pop2;
    jtsc_pkg::ctx_t                  pctx;

    assign cnt_ext = DW'(count);
    assign cnt_one = (count == CW'(1));
    assign cnt_ge2 = (count >= CW'(2));
    assign cnt_ge3 = (count >= CW'(3));
    assign top_ctx = (count == '0) ? jtsc_pkg::CTX_NONE : top0;

    // Limit is the smaller of max_depth and the stack size
    assign lim_hit = (cnt_ext >= DW'(max_depth)) || (count == CW'(STACK_DEPTH));

    assign need_ctx = (tok.token_kind == jtsc_pkg::KIND_OBJ_CLOSE) ?
                      jtsc_pkg::CTX_OBJECT : jtsc_pkg::CTX_ARRAY;

    // Close of the top context
    always_comb
    begin
        cl_err  = 1'b0;
        cl_pop1 = 1'b0;
        cl_pop2 = 1'b0;
        cl_mask = mask;
        if (top_ctx != need_ctx)
        begin
            cl_err = 1'b1;
        end
        else if (cnt_one)
        begin
            // outermost context stays on the stack, only the end may follow
            cl_mask = jtsc_pkg::EX_DOC_END;
        end
        else if (top1 == jtsc_pkg::CTX_KEY && cnt_ge3)
        begin
            cl_pop2 = 1'b1;
            cl_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_OBJ_END;
        end
        else if (top1 == jtsc_pkg::CTX_ARRAY)
        begin
            cl_pop1 = 1'b1;
            cl_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_ARR_END;
        end
        else
        begin
            cl_err = 1'b1;
        end
    end

    // Main decode
    always_comb
    begin
        err  = jtsc_pkg::ERR_NONE;
        st   = jtsc_pkg::STATUS_CONT;
        ev   = jtsc_pkg::EV_NONE;
        m_n  = mask;
        c_n  = count;
        push = 1'b0;
        pop1 = 1'b0;
        pop2 = 1'b0;
        pctx = jtsc_pkg::CTX_NONE;

        case (tok.token_kind) inside
            jtsc_pkg::KIND_END:
            begin
                if ((mask & jtsc_pkg::EX_DOC_END) != '0)
                begin
                    st = jtsc_pkg::STATUS_COMPLETE;
                    ev = jtsc_pkg::EV_END;
                end
                else
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
            end
            jtsc_pkg::KIND_OBJ_OPEN,
            jtsc_pkg::KIND_ARR_OPEN:
            begin
                if (tok.token_kind == jtsc_pkg::KIND_OBJ_OPEN &&
                    (mask & jtsc_pkg::EX_OBJ_BEGIN) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else if (tok.token_kind == jtsc_pkg::KIND_ARR_OPEN &&
                         (mask & jtsc_pkg::EX_ARR_BEGIN) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else if (lim_hit)
                begin
                    err = jtsc_pkg::ERR_OVERFLOW;
                end
                else if (tok.token_kind == jtsc_pkg::KIND_OBJ_OPEN)
                begin
                    push = 1'b1;
                    pctx = jtsc_pkg::CTX_OBJECT;
                    c_n  = count + CW'(1);
                    m_n  = jtsc_pkg::EX_OBJ_KEY | jtsc_pkg::EX_OBJ_END;
                    ev   = jtsc_pkg::EV_OBJ_OPEN;
                end
                else
                begin
                    push = 1'b1;
                    pctx = jtsc_pkg::CTX_ARRAY;
                    c_n  = count + CW'(1);
                    m_n  = jtsc_pkg::EX_ARR_VALUE | jtsc_pkg::EX_OBJ_BEGIN |
                           jtsc_pkg::EX_ARR_BEGIN | jtsc_pkg::EX_ARR_END;
                    ev   = jtsc_pkg::EV_ARR_OPEN;
                end
            end
            jtsc_pkg::KIND_OBJ_CLOSE,
            jtsc_pkg::KIND_ARR_CLOSE:
            begin
                if (tok.token_kind == jtsc_pkg::KIND_OBJ_CLOSE &&
                    (mask & jtsc_pkg::EX_OBJ_END) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else if (tok.token_kind == jtsc_pkg::KIND_ARR_CLOSE &&
                         (mask & jtsc_pkg::EX_ARR_END) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else if (cl_err)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else
                begin
                    pop1 = cl_pop1;
                    pop2 = cl_pop2;
                    m_n  = cl_mask;
                    if (cl_pop2)
                    begin
                        c_n = count - CW'(2);
                    end
                    else if (cl_pop1)
                    begin
                        c_n = count - CW'(1);
                    end
                    ev = (tok.token_kind == jtsc_pkg::KIND_OBJ_CLOSE) ?
                         jtsc_pkg::EV_OBJ_CLOSE : jtsc_pkg::EV_ARR_CLOSE;
                end
            end
            jtsc_pkg::KIND_COLON:
            begin
                if ((mask & jtsc_pkg::EX_COLON) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else
                begin
                    m_n = jtsc_pkg::EX_OBJ_BEGIN | jtsc_pkg::EX_ARR_BEGIN |
                          jtsc_pkg::EX_OBJ_VALUE;
                    ev  = jtsc_pkg::EV_SEP;
                end
            end
            jtsc_pkg::KIND_COMMA:
            begin
                if ((mask & jtsc_pkg::EX_COMMA) == '0)
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
                else
                begin
                    // a comma with neither close class pending leaves the mask as is
                    if ((mask & jtsc_pkg::EX_OBJ_END) != '0)
                    begin
                        m_n = jtsc_pkg::EX_OBJ_KEY;
                    end
                    else if ((mask & jtsc_pkg::EX_ARR_END) != '0)
                    begin
                        m_n = jtsc_pkg::EX_OBJ_BEGIN | jtsc_pkg::EX_ARR_BEGIN |
                              jtsc_pkg::EX_ARR_VALUE;
                    end
                    ev = jtsc_pkg::EV_SEP;
                end
            end
            [jtsc_pkg::KIND_STRING:jtsc_pkg::KIND_NULL]:
            begin
                if (tok.token_kind == jtsc_pkg::KIND_STRING &&
                    (mask & jtsc_pkg::EX_OBJ_KEY) != '0)
                begin
                    // member name
                    if (!tok.lexeme_ok)
                    begin
                        err = jtsc_pkg::ERR_LEXEME;
                    end
                    else if (lim_hit)
                    begin
                        err = jtsc_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        push = 1'b1;
                        pctx = jtsc_pkg::CTX_KEY;
                        c_n  = count + CW'(1);
                        m_n  = jtsc_pkg::EX_COLON;
                        ev   = jtsc_pkg::EV_KEY;
                    end
                end
                else if ((mask & jtsc_pkg::EX_OBJ_VALUE) != '0)
                begin
                    // member value closes the pending key
                    if (!cnt_ge2 || top_ctx != jtsc_pkg::CTX_KEY)
                    begin
                        err = jtsc_pkg::ERR_UNEXPECTED;
                    end
                    else if (!tok.lexeme_ok)
                    begin
                        err = jtsc_pkg::ERR_LEXEME;
                    end
                    else
                    begin
                        pop1 = 1'b1;
                        c_n  = count - CW'(1);
                        m_n  = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_OBJ_END;
                        ev   = jtsc_pkg::EV_MEMBER;
                    end
                end
                else if ((mask & jtsc_pkg::EX_ARR_VALUE) != '0)
                begin
                    if (top_ctx != jtsc_pkg::CTX_ARRAY)
                    begin
                        err = jtsc_pkg::ERR_UNEXPECTED;
                    end
                    else if (!tok.lexeme_ok)
                    begin
                        err = jtsc_pkg::ERR_LEXEME;
                    end
                    else
                    begin
                        m_n = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_ARR_END;
                        ev  = jtsc_pkg::EV_ELEMENT;
                    end
                end
                else
                begin
                    err = jtsc_pkg::ERR_UNEXPECTED;
                end
            end
            default:
            begin
                err = jtsc_pkg::ERR_INVALID;
            end
        endcase

        // Error or complete document: restart, stack contents are left as they are
        if (err != jtsc_pkg::ERR_NONE)
        begin
            st   = jtsc_pkg::STATUS_ERROR;
            ev   = jtsc_pkg::EV_NONE;
            m_n  = jtsc_pkg::MASK_RESTART;
            c_n  = '0;
            push = 1'b0;
            pop1 = 1'b0;
            pop2 = 1'b0;
        end
        else if (st == jtsc_pkg::STATUS_COMPLETE)
        begin
            m_n = jtsc_pkg::MASK_RESTART;
            c_n = '0;
        end
    end

    assign cnt_out_ext = DW'(c_n);

    assign mask_next  = m_n;
    assign count_next = c_n;

    assign op.push     = fire & push;
    assign op.pop1     = fire & pop1;
    assign op.pop2     = fire & pop2;
    assign op.push_ctx = pctx;

    assign result.status     = st;
    assign result.event_res  = ev;
    assign result.error_kind = err;
    assign result.depth      = cnt_out_ext[jtsc_pkg::DEPTH_W-1:0];

endmodule

// File: design/json_token_structure_checker_unit.sv
// JSON token structure checker. Takes one lexed token per transaction on the tok channel
// and returns one result per token on the res channel: status, structural event, error
// kind and stack depth. A new token is taken in every cycle in which the output register
// is free or drained; its result is held in that register and appears in the cycle after
// acceptance. A token is still taken while that register holds a result if the result
// is taken in the same cycle. The open contexts live in a row of STACK_DEPTH shift cells
// whose top entry sits in the first cell; a push or a pop is one shift of the whole row.
// The stack needs no clearing after reset. max_depth is written through the APB port at
// byte address 0 and should only be changed while no token is in flight.
module json_token_structure_checker_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // token input
    input  logic                  tok_valid,
    output logic                  tok_ready,
    input  jtsc_pkg::tok_t        tok,
    // result output
    output logic                  res_valid,
    input  logic                  res_ready,
    output jtsc_pkg::res_t        res,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                          fire;
    jtsc_pkg::mask_t               mask_reg;
    jtsc_pkg::mask_t               mask_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [jtsc_pkg::DEPTH_W-1:0]  max_depth_reg;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    jtsc_pkg::res_t                res_reg;
    jtsc_pkg::res_t                res_next;
    jtsc_pkg::stack_op_t           op;
    jtsc_pkg::ctx_t                ctx_w [0:STACK_DEPTH+1];

    // Handshake: accept whenever the output register is free or being drained
    assign tok_ready = !res_valid_reg || res_ready;
    assign fire      = tok_valid && tok_ready;

    // Decode
    jtsc_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_ctrl (
        .fire       (fire),
        .tok        (tok),
        .mask       (mask_reg),
        .count      (count_reg),
        .top0       (ctx_w[0]),
        .top1       (ctx_w[1]),
        .max_depth  (max_depth_reg),
        .mask_next  (mask_next),
        .count_next (count_next),
        .op         (op),
        .result     (res_next)
    );

    // Context stack: row of shift cells, entries past the end read as empty
    assign ctx_w[STACK_DEPTH]     = jtsc_pkg::CTX_NONE;
    assign ctx_w[STACK_DEPTH + 1] = jtsc_pkg::CTX_NONE;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            jtsc_cell u_cell (
                .clk        (clk),
                .op         (op),
                .from_prev  (op.push_ctx),
                .from_next  (ctx_w[i + 1]),
                .from_next2 (ctx_w[i + 2]),
                .ctx        (ctx_w[i])
            );
        end
        else
        begin : g_body
            jtsc_cell u_cell (
                .clk        (clk),
                .op         (op),
                .from_prev  (ctx_w[i - 1]),
                .from_next  (ctx_w[i + 1]),
                .from_next2 (ctx_w[i + 2]),
                .ctx        (ctx_w[i])
            );
        end
    end

    // Checker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= jtsc_pkg::MASK_RESTART;
            count_reg <= '0;
        end
        else if (fire)
        begin
            mask_reg  <= mask_next;
            count_reg <= count_next;
        end
    end

    // Output register
    assign res_valid_next = fire || (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= jtsc_pkg::MAX_DEPTH_RESET;
        end
        else if (psel && penable && pwrite && paddr == jtsc_pkg::ADDR_MAX_DEPTH)
        begin
            max_depth_reg <= pwdata[jtsc_pkg::DEPTH_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == jtsc_pkg::ADDR_MAX_DEPTH) ?
                    {{(32 - jtsc_pkg::DEPTH_W){1'b0}}, max_depth_reg} : 32'd0;

endmodule

// File: design/jtsc_checker.sv
// Port-level checks on the structure checker
module jtsc_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tok_valid,
    input  logic           tok_ready,
    input  logic           res_valid,
    input  logic           res_ready,
    input  jtsc_pkg::res_t res
);

    // An error result carries no event and reports an empty stack
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == jtsc_pkg::STATUS_ERROR |->
            res.event_res == jtsc_pkg::EV_NONE && res.depth == '0 &&
            res.error_kind != jtsc_pkg::ERR_NONE)
        else $error("error result with event or depth");

    // A complete document ends with the end event at depth zero
    a_complete_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == jtsc_pkg::STATUS_COMPLETE |->
            res.event_res == jtsc_pkg::EV_END && res.depth == '0 &&
            res.error_kind == jtsc_pkg::ERR_NONE)
        else $error("complete result malformed");

    // A continuing result always has an event and no error
    a_cont_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == jtsc_pkg::STATUS_CONT |->
            res.event_res != jtsc_pkg::EV_NONE && res.error_kind == jtsc_pkg::ERR_NONE)
        else $error("continue result without event");

    // An empty output register never blocks the token side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> tok_ready)
        else $error("token stalled with empty output");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

endmodule

bind json_token_structure_checker_unit jtsc_checker u_jtsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// File: bench/tb_json_token_structure_checker_unit.sv
`timescale 1ns / 1ps

module tb_json_token_structure_checker_unit;

    localparam int STACK_DEPTH = 64;

    // Token kinds with no name in the package: all of them are invalid
    localparam logic [jtsc_pkg::KIND_W-1:0] KIND_INVALID_LO = 4'd11;
    localparam logic [jtsc_pkg::KIND_W-1:0] KIND_INVALID_HI = 4'd15;

    // Results that can be read straight off the grammar
    localparam jtsc_pkg::res_t RES_UNEXPECTED =
        '{jtsc_pkg::STATUS_ERROR, jtsc_pkg::EV_NONE, jtsc_pkg::ERR_UNEXPECTED, 7'd0};
    localparam jtsc_pkg::res_t RES_INVALID =
        '{jtsc_pkg::STATUS_ERROR, jtsc_pkg::EV_NONE, jtsc_pkg::ERR_INVALID, 7'd0};
    localparam jtsc_pkg::res_t RES_LEXEME =
        '{jtsc_pkg::STATUS_ERROR, jtsc_pkg::EV_NONE, jtsc_pkg::ERR_LEXEME, 7'd0};
    localparam jtsc_pkg::res_t RES_DONE =
        '{jtsc_pkg::STATUS_COMPLETE, jtsc_pkg::EV_END, jtsc_pkg::ERR_NONE, 7'd0};
    localparam jtsc_pkg::res_t RES_OBJ_OPEN_1 =
        '{jtsc_pkg::STATUS_CONT, jtsc_pkg::EV_OBJ_OPEN, jtsc_pkg::ERR_NONE, 7'd1};
    localparam jtsc_pkg::res_t RES_ARR_OPEN_1 =
        '{jtsc_pkg::STATUS_CONT, jtsc_pkg::EV_ARR_OPEN, jtsc_pkg::ERR_NONE, 7'd1};
    localparam jtsc_pkg::res_t RES_UNTYPED = '0;

    typedef struct {
        jtsc_pkg::tok_t tk;
        bit             typed;
        jtsc_pkg::res_t want;
    } dir_row_t;

    localparam int N_DIRECTED = 24;
    localparam int N_PHASES   = 6;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           tok_valid = 1'b0;
    logic           tok_ready;
    jtsc_pkg::tok_t tok = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    jtsc_pkg::res_t res;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    json_token_structure_checker_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .tok_valid(tok_valid),
        .tok_ready(tok_ready),
        .tok(tok),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Shadow of the checker state
    jtsc_pkg::mask_t              tracked_mask = jtsc_pkg::MASK_RESTART;
    jtsc_pkg::ctx_t               ctx_row [STACK_DEPTH];
    int                           open_count = 0;
    logic [jtsc_pkg::DEPTH_W-1:0] cfg_max_depth = jtsc_pkg::MAX_DEPTH_RESET;

    jtsc_pkg::res_t pending_results [$];
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   doc_target = 1;
    int   send_idle_pct = 34;
    int   recv_idle_pct = 55;
    bit   hold_request = 1'b0;
    int   hold_left = 0;

    // Errors and an empty array document first, then a full document with nested object and array
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{'{jtsc_pkg::KIND_END, 1'b1}, 1'b1, RES_UNEXPECTED},
        '{'{KIND_INVALID_LO, 1'b0}, 1'b1, RES_INVALID},
        '{'{KIND_INVALID_HI, 1'b1}, 1'b1, RES_INVALID},
        '{'{jtsc_pkg::KIND_OBJ_OPEN, 1'b0}, 1'b1, RES_OBJ_OPEN_1},
        '{'{jtsc_pkg::KIND_OBJ_OPEN, 1'b1}, 1'b1, RES_UNEXPECTED},
        '{'{jtsc_pkg::KIND_ARR_OPEN, 1'b0}, 1'b1, RES_ARR_OPEN_1},
        '{'{jtsc_pkg::KIND_STRING, 1'b0}, 1'b1, RES_LEXEME},
        '{'{jtsc_pkg::KIND_ARR_OPEN, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_ARR_CLOSE, 1'b0}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_END, 1'b1}, 1'b1, RES_DONE},
        '{'{jtsc_pkg::KIND_OBJ_OPEN, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_STRING, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_COLON, 1'b0}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_ARR_OPEN, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_BOOL, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_COMMA, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_NULL, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_ARR_CLOSE, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_COMMA, 1'b0}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_STRING, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_COLON, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_NUMBER, 1'b1}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_OBJ_CLOSE, 1'b0}, 1'b0, RES_UNTYPED},
        '{'{jtsc_pkg::KIND_END, 1'b0}, 1'b1, RES_DONE}
    };

    // max_depth per phase, extremes included, and the number of random tokens
    logic [jtsc_pkg::DEPTH_W-1:0] phase_depth [N_PHASES] =
        '{7'd1, 7'd127, 7'd0, 7'd2, 7'd5, jtsc_pkg::MAX_DEPTH_RESET};
    int phase_items [N_PHASES] = '{200, 300, 100, 200, 300, 550};

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ---------------- shadow model ----------------

    function automatic void restart_doc();
        tracked_mask = jtsc_pkg::MASK_RESTART;
        open_count   = 0;
    endfunction

    function automatic jtsc_pkg::ctx_t top_context();
        if (open_count == 0 || open_count > STACK_DEPTH)
            return jtsc_pkg::CTX_NONE;
        return ctx_row[open_count-1];
    endfunction

    function automatic logic [jtsc_pkg::ERROR_W-1:0] push_context(input jtsc_pkg::ctx_t c);
        int lim;
        lim = (int'(cfg_max_depth) < STACK_DEPTH) ? int'(cfg_max_depth) : STACK_DEPTH;
        if (open_count >= lim)
            return jtsc_pkg::ERR_OVERFLOW;
        ctx_row[open_count] = c;
        open_count++;
        return jtsc_pkg::ERR_NONE;
    endfunction

    // Close of the top context; the outermost one is kept and only end may follow
    function automatic logic [jtsc_pkg::ERROR_W-1:0] close_context(input jtsc_pkg::ctx_t need);
        jtsc_pkg::ctx_t t;
        if (top_context() != need)
            return jtsc_pkg::ERR_UNEXPECTED;
        if (open_count == 1)
        begin
            tracked_mask = jtsc_pkg::EX_DOC_END;
            return jtsc_pkg::ERR_NONE;
        end
        open_count--;
        t = top_context();
        if (t == jtsc_pkg::CTX_KEY && open_count >= 2)
        begin
            open_count--;
            tracked_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_OBJ_END;
            return jtsc_pkg::ERR_NONE;
        end
        if (t == jtsc_pkg::CTX_ARRAY)
        begin
            tracked_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_ARR_END;
            return jtsc_pkg::ERR_NONE;
        end
        return jtsc_pkg::ERR_UNEXPECTED;
    endfunction

    function automatic jtsc_pkg::res_t predict_outcome(input jtsc_pkg::tok_t t);
        logic [jtsc_pkg::STATUS_W-1:0] st;
        logic [jtsc_pkg::EVENT_W-1:0]  ev;
        logic [jtsc_pkg::ERROR_W-1:0]  err;
        jtsc_pkg::res_t                r;
        st  = jtsc_pkg::STATUS_CONT;
        ev  = jtsc_pkg::EV_NONE;
        err = jtsc_pkg::ERR_NONE;
        case (t.token_kind)
            jtsc_pkg::KIND_END:
                if (|(tracked_mask & jtsc_pkg::EX_DOC_END))
                begin
                    st = jtsc_pkg::STATUS_COMPLETE;
                    ev = jtsc_pkg::EV_END;
                end
                else
                    err = jtsc_pkg::ERR_UNEXPECTED;
            jtsc_pkg::KIND_OBJ_OPEN:
                if (!(|(tracked_mask & jtsc_pkg::EX_OBJ_BEGIN)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    err = push_context(jtsc_pkg::CTX_OBJECT);
                    if (err == jtsc_pkg::ERR_NONE)
                    begin
                        tracked_mask = jtsc_pkg::EX_OBJ_KEY | jtsc_pkg::EX_OBJ_END;
                        ev = jtsc_pkg::EV_OBJ_OPEN;
                    end
                end
            jtsc_pkg::KIND_OBJ_CLOSE:
                if (!(|(tracked_mask & jtsc_pkg::EX_OBJ_END)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    err = close_context(jtsc_pkg::CTX_OBJECT);
                    if (err == jtsc_pkg::ERR_NONE)
                        ev = jtsc_pkg::EV_OBJ_CLOSE;
                end
            jtsc_pkg::KIND_ARR_OPEN:
                if (!(|(tracked_mask & jtsc_pkg::EX_ARR_BEGIN)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    err = push_context(jtsc_pkg::CTX_ARRAY);
                    if (err == jtsc_pkg::ERR_NONE)
                    begin
                        tracked_mask = jtsc_pkg::EX_ARR_VALUE | jtsc_pkg::EX_OBJ_BEGIN |
                                       jtsc_pkg::EX_ARR_BEGIN | jtsc_pkg::EX_ARR_END;
                        ev = jtsc_pkg::EV_ARR_OPEN;
                    end
                end
            jtsc_pkg::KIND_ARR_CLOSE:
                if (!(|(tracked_mask & jtsc_pkg::EX_ARR_END)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    err = close_context(jtsc_pkg::CTX_ARRAY);
                    if (err == jtsc_pkg::ERR_NONE)
                        ev = jtsc_pkg::EV_ARR_CLOSE;
                end
            jtsc_pkg::KIND_COLON:
                if (!(|(tracked_mask & jtsc_pkg::EX_COLON)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    tracked_mask = jtsc_pkg::EX_OBJ_BEGIN | jtsc_pkg::EX_ARR_BEGIN |
                                   jtsc_pkg::EX_OBJ_VALUE;
                    ev = jtsc_pkg::EV_SEP;
                end
            jtsc_pkg::KIND_COMMA:
                if (!(|(tracked_mask & jtsc_pkg::EX_COMMA)))
                    err = jtsc_pkg::ERR_UNEXPECTED;
                else
                begin
                    // mask stays as it is when no close class is expected
                    if (|(tracked_mask & jtsc_pkg::EX_OBJ_END))
                        tracked_mask = jtsc_pkg::EX_OBJ_KEY;
                    else if (|(tracked_mask & jtsc_pkg::EX_ARR_END))
                        tracked_mask = jtsc_pkg::EX_OBJ_BEGIN | jtsc_pkg::EX_ARR_BEGIN |
                                       jtsc_pkg::EX_ARR_VALUE;
                    ev = jtsc_pkg::EV_SEP;
                end
            jtsc_pkg::KIND_STRING, jtsc_pkg::KIND_BOOL,
            jtsc_pkg::KIND_NUMBER, jtsc_pkg::KIND_NULL:
                if (t.token_kind == jtsc_pkg::KIND_STRING &&
                    |(tracked_mask & jtsc_pkg::EX_OBJ_KEY))
                begin
                    if (!t.lexeme_ok)
                        err = jtsc_pkg::ERR_LEXEME;
                    else
                    begin
                        err = push_context(jtsc_pkg::CTX_KEY);
                        if (err == jtsc_pkg::ERR_NONE)
                        begin
                            tracked_mask = jtsc_pkg::EX_COLON;
                            ev = jtsc_pkg::EV_KEY;
                        end
                    end
                end
                else if (|(tracked_mask & jtsc_pkg::EX_OBJ_VALUE))
                begin
                    if (open_count < 2 || top_context() != jtsc_pkg::CTX_KEY)
                        err = jtsc_pkg::ERR_UNEXPECTED;
                    else if (!t.lexeme_ok)
                        err = jtsc_pkg::ERR_LEXEME;
                    else
                    begin
                        open_count--;
                        tracked_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_OBJ_END;
                        ev = jtsc_pkg::EV_MEMBER;
                    end
                end
                else if (|(tracked_mask & jtsc_pkg::EX_ARR_VALUE))
                begin
                    if (top_context() != jtsc_pkg::CTX_ARRAY)
                        err = jtsc_pkg::ERR_UNEXPECTED;
                    else if (!t.lexeme_ok)
                        err = jtsc_pkg::ERR_LEXEME;
                    else
                    begin
                        tracked_mask = jtsc_pkg::EX_COMMA | jtsc_pkg::EX_ARR_END;
                        ev = jtsc_pkg::EV_ELEMENT;
                    end
                end
                else
                    err = jtsc_pkg::ERR_UNEXPECTED;
            default:
                err = jtsc_pkg::ERR_INVALID;
        endcase

        if (err != jtsc_pkg::ERR_NONE)
        begin
            st = jtsc_pkg::STATUS_ERROR;
            ev = jtsc_pkg::EV_NONE;
            restart_doc();
        end
        else if (st == jtsc_pkg::STATUS_COMPLETE)
            restart_doc();

        r.status     = st;
        r.event_res  = ev;
        r.error_kind = err;
        r.depth      = jtsc_pkg::DEPTH_W'(open_count);
        return r;
    endfunction

    // ---------------- token generator ----------------

    // Mostly legal tokens for the current mask, nesting towards a per-document
    // target depth; a few stray tokens and bad lexemes break sequences.
    function automatic jtsc_pkg::tok_t pick_token();
        jtsc_pkg::tok_t  t;
        jtsc_pkg::mask_t m;
        int    close_w;
        int    open_w;
        int    r;
        m = tracked_mask;
        t.lexeme_ok = 1'($urandom_range(1));
        if (open_count == 0 && m == jtsc_pkg::MASK_RESTART)
            doc_target = ($urandom_range(99) < 8) ? $urandom_range(66, 60)
                                                  : $urandom_range(6, 1);
        if ($urandom_range(99) < 7)
        begin
            t.token_kind = jtsc_pkg::KIND_W'($urandom_range(15));
            return t;
        end
        close_w = (open_count >= doc_target) ? 60 : 12;
        open_w  = (open_count <  doc_target) ? 55 : 10;
        r = $urandom_range(99);
        if (|(m & jtsc_pkg::EX_DOC_END))
            t.token_kind = jtsc_pkg::KIND_END;
        else if (|(m & jtsc_pkg::EX_COLON))
            t.token_kind = jtsc_pkg::KIND_COLON;
        else if (|(m & jtsc_pkg::EX_COMMA))
        begin
            if (r < close_w)
                t.token_kind = (|(m & jtsc_pkg::EX_OBJ_END)) ? jtsc_pkg::KIND_OBJ_CLOSE
                                                             : jtsc_pkg::KIND_ARR_CLOSE;
            else
                t.token_kind = jtsc_pkg::KIND_COMMA;
        end
        else if (|(m & jtsc_pkg::EX_OBJ_KEY))
        begin
            if (r < close_w / 3)
                t.token_kind = jtsc_pkg::KIND_OBJ_CLOSE;
            else
            begin
                t.token_kind = jtsc_pkg::KIND_STRING;
                t.lexeme_ok  = ($urandom_range(99) >= 3);
            end
        end
        else if (|(m & jtsc_pkg::EX_ARR_END) && r < close_w / 3)
            t.token_kind = jtsc_pkg::KIND_ARR_CLOSE;
        else if (open_count == 0 || $urandom_range(99) < open_w)
            t.token_kind = ($urandom_range(1) == 0) ? jtsc_pkg::KIND_OBJ_OPEN
                                                    : jtsc_pkg::KIND_ARR_OPEN;
        else
        begin
            t.token_kind = jtsc_pkg::KIND_W'($urandom_range(jtsc_pkg::KIND_NULL,
                                                            jtsc_pkg::KIND_STRING));
            t.lexeme_ok  = ($urandom_range(99) >= 3);
        end
        return t;
    endfunction

    // ---------------- drivers ----------------

    // One token transaction; the expectation is stored once it is accepted
    task automatic send_token(input jtsc_pkg::tok_t t, input bit typed,
                              input jtsc_pkg::res_t typed_want);
        bit             fired;
        jtsc_pkg::res_t want;
        if (items_sent < 560)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 55;
        end
        else if (items_sent < 1120)
        begin
            send_idle_pct = 55;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            tok_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        tok_valid <= 1'b1;
        tok       <= t;
        // handshake signals are settled by the falling edge
        do
        begin
            @(negedge clk);
            fired = tok_ready;
            @(posedge clk);
        end
        while (!fired);
        want = predict_outcome(t);
        if (typed)
            want = typed_want;
        pending_results.push_back(want);
        items_sent++;
    endtask

    // Stop offering and let every outstanding result drain
    task automatic wait_idle();
        tok_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_depth(input logic [jtsc_pkg::DEPTH_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= jtsc_pkg::ADDR_MAX_DEPTH;
        pwdata  <= {{(32-jtsc_pkg::DEPTH_W){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register taken at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_max_depth = v;
    endtask

    // Result side: random back-pressure plus one long counted hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = 48;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result check, sampled between edges
    always @(negedge clk)
    begin
        jtsc_pkg::res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d event %0d error %0d depth %0d",
                             res.status, res.event_res, res.error_kind, res.depth);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.status !== want.status || res.event_res !== want.event_res ||
                    res.error_kind !== want.error_kind || res.depth !== want.depth)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st %0d ev %0d err %0d dep %0d, got %0d %0d %0d %0d",
                                 want.status, want.event_res, want.error_kind, want.depth,
                                 res.status, res.event_res, res.error_kind, res.depth);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // ---------------- sequence ----------------

    initial
    begin
        int random_count;
        random_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_token(directed_rows[i].tk, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            write_max_depth(phase_depth[p]);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                random_count++;
                // sender pauses until the result side is empty
                if (random_count == 700)
                    wait_idle();
                // long stall on the result side while tokens keep coming
                if (random_count == 1300)
                    hold_request = 1'b1;
                send_token(pick_token(), 1'b0, RES_UNTYPED);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
